@@ design/dfa_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the table-driven string acceptor.
package dfa_pkg;

  localparam int ST_W    = 6;
  localparam int SYM_W   = 8;
  localparam int ENTRY_W = 2 * ST_W + SYM_W;
  localparam int NACC    = 2 ** ST_W;

  localparam int E_TO_LO   = 0;
  localparam int E_SYM_LO  = ST_W;
  localparam int E_FROM_LO = ST_W + SYM_W;

  localparam int EIU_W  = 7;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 64;

  localparam logic [CFG_IW-1:0] CFG_INITIAL_STATE  = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_ACCEPT_MASK    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_ENTRIES_IN_USE = 2'd2;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OUT_ACCEPTED = 2'd0,
    OUT_REJECTED = 2'd1,
    OUT_NO_MOVE  = 2'd2
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic             sym;
    logic             last;
    logic             slot_ok;
    logic [ST_W-1:0]  slot;
    logic [ST_W-1:0]  from_st;
    logic [SYM_W-1:0] symbol;
    logic [ST_W-1:0]  to_st;
  } cmd_t;

  typedef struct packed {
    logic              we;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic in_string;
    logic dead;
  } back_stat_t;

endpackage

@@ design/dfa_if.sv @@
`timescale 1ns / 1ps
// Item channel interfaces of the string acceptor.
interface dfa_in_if import dfa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [ST_W-1:0]  entry_index;
  logic [ST_W-1:0]  from_state;
  logic [SYM_W-1:0] symbol;
  logic [ST_W-1:0]  to_state;
  logic             last_symbol;

  modport source (output valid, kind, entry_index, from_state, symbol, to_state,
                  last_symbol, input ready);
  modport sink (input valid, kind, entry_index, from_state, symbol, to_state,
                last_symbol, output ready);
endinterface

interface dfa_out_if import dfa_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [1:0]      outcome;
  logic [ST_W-1:0] final_state;

  modport source (output valid, outcome, final_state, input ready);
  modport sink (input valid, outcome, final_state, output ready);
endinterface

@@ design/dfa_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port RAM with registered read.
module dfa_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                            wdata,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

@@ design/dfa_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts items, classifies them and queues commands for the back end.
module dfa_front import dfa_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  dfa_in_if.sink   in_ch,
  output cmd_t     cmd,
  output logic     cmd_valid,
  input  logic     cmd_ready
);

  cmd_t            q_r [Q_DEPTH];
  logic [Q_AW-1:0] wptr_r, wptr_nxt;
  logic [Q_AW-1:0] rptr_r, rptr_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  logic            push, pop;
  cmd_t            in_cmd;

  always_comb begin
    in_cmd.sym     = in_ch.kind;
    in_cmd.last    = in_ch.last_symbol;
    in_cmd.slot_ok = int'(in_ch.entry_index) < TABLE_DEPTH;
    in_cmd.slot    = in_ch.entry_index;
    in_cmd.from_st = in_ch.from_state;
    in_cmd.symbol  = in_ch.symbol;
    in_cmd.to_st   = in_ch.to_state;
  end

  assign in_ch.ready = (cnt_r != Q_CW'(Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (cnt_r != '0);
  assign pop         = cmd_valid && cmd_ready;
  assign cmd         = q_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + Q_AW'(1) : wptr_r;
    rptr_nxt = pop ? rptr_r + Q_AW'(1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= in_cmd;
    end
  end

endmodule

@@ design/dfa_back.sv @@
`timescale 1ns / 1ps
// Back end: table writes, sequential first-match search, configuration and result register.
module dfa_back import dfa_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int NUM_STATES  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  input  cfg_wr_t     cfg,
  dfa_out_if.source   out_ch,
  output back_stat_t  stat
);

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int SW1 = ST_W + 1;

  back_state_t       state_r, state_nxt;
  logic [AW-1:0]     cnt_r, cnt_nxt;
  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic              last_r, last_nxt;
  logic [ST_W-1:0]   cur_r, cur_nxt;
  logic              dead_r, dead_nxt;
  logic              in_str_r, in_str_nxt;
  logic [ST_W-1:0]   init_r, init_nxt;
  logic [NACC-1:0]   amask_r, amask_nxt;
  logic [EIU_W-1:0]  eiu_r, eiu_nxt;
  logic              out_valid_r, out_valid_nxt;
  outcome_t          out_outcome_r, out_outcome_nxt;
  logic [ST_W-1:0]   out_state_r, out_state_nxt;

  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0]     n_lim;
  logic              scan_end, hit, acc, out_free, sym_pop;
  outcome_t          outcome;

  dfa_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (int'(eiu_r) > TABLE_DEPTH) begin
      n_lim = CW'(TABLE_DEPTH);
    end else begin
      n_lim = CW'(eiu_r);
    end
  end

  assign scan_end = (CW'(cnt_r) + CW'(1)) == n_lim;
  assign hit      = (ram_rdata[E_FROM_LO +: ST_W] == cur_r) &&
                    (ram_rdata[E_SYM_LO +: SYM_W] == sym_r);
  assign acc      = ({1'b0, cur_r} < SW1'(NUM_STATES)) && amask_r[cur_r];
  assign outcome  = dead_r ? OUT_NO_MOVE : (acc ? OUT_ACCEPTED : OUT_REJECTED);
  assign out_free = !out_valid_r || out_ch.ready;
  assign sym_pop  = (state_r == ST_IDLE) && cmd_valid && cmd.sym;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (sym_pop && !dead_r && (n_lim != '0)) begin
          state_nxt = ST_SCAN;
        end else if (sym_pop && cmd.last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SCAN: begin
        if (hit || scan_end) begin
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready       = (state_r == ST_IDLE);
    ram_we          = 1'b0;
    ram_addr        = '0;
    ram_wdata       = {cmd.from_st, cmd.symbol, cmd.to_st};
    cnt_nxt         = cnt_r;
    sym_nxt         = sym_r;
    last_nxt        = last_r;
    cur_nxt         = cur_r;
    dead_nxt        = dead_r;
    in_str_nxt      = in_str_r;
    init_nxt        = init_r;
    amask_nxt       = amask_r;
    eiu_nxt         = eiu_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_outcome_nxt = out_outcome_r;
    out_state_nxt   = out_state_r;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid && !cmd.sym) begin
          ram_we   = cmd.slot_ok;
          ram_addr = AW'(cmd.slot);
        end else if (sym_pop) begin
          in_str_nxt = 1'b1;
          sym_nxt    = cmd.symbol;
          last_nxt   = cmd.last;
          cnt_nxt    = '0;
          if (!dead_r && (n_lim == '0)) begin
            dead_nxt = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          cur_nxt = ram_rdata[E_TO_LO +: ST_W];
        end else if (scan_end) begin
          dead_nxt = 1'b1;
        end else begin
          cnt_nxt  = cnt_r + AW'(1);
          ram_addr = cnt_r + AW'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_outcome_nxt = outcome;
          out_state_nxt   = cur_r;
          cur_nxt         = init_r;
          dead_nxt        = 1'b0;
          in_str_nxt      = 1'b0;
        end
      end
      default: ;
    endcase

    if (cfg.we) begin
      unique case (cfg.index)
        CFG_INITIAL_STATE: begin
          init_nxt = cfg.data[ST_W-1:0];
          if (!in_str_r) begin
            cur_nxt = cfg.data[ST_W-1:0];
          end
        end
        CFG_ACCEPT_MASK:    amask_nxt = cfg.data[NACC-1:0];
        CFG_ENTRIES_IN_USE: eiu_nxt   = cfg.data[EIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      dead_r      <= 1'b0;
      in_str_r    <= 1'b0;
      init_r      <= '0;
      amask_r     <= '0;
      eiu_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      dead_r      <= dead_nxt;
      in_str_r    <= in_str_nxt;
      init_r      <= init_nxt;
      amask_r     <= amask_nxt;
      eiu_r       <= eiu_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r         <= cnt_nxt;
    sym_r         <= sym_nxt;
    last_r        <= last_nxt;
    out_outcome_r <= out_outcome_nxt;
    out_state_r   <= out_state_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.outcome     = out_outcome_r;
  assign out_ch.final_state = out_state_r;
  assign stat.in_string     = in_str_r;
  assign stat.dead          = dead_r;

endmodule

@@ design/dfa_string_acceptor.sv @@
`timescale 1ns / 1ps
// Top level of the table-driven string acceptor.
//
// Items arrive on in_ch (valid/ready). kind 0 writes one transition entry
// (from_state, symbol, to_state) to table slot entry_index; kind 1 is a string
// symbol. The symbol flagged last_symbol gives one result on out_ch: outcome
// (accepted, ended non-accepting, no transition) and final_state.
// Registers are written through cfg_we / cfg_index / cfg_wdata, by the user only
// while idle (the block does not enforce this): 0 initial_state, 1 accept_mask,
// 2 entries_in_use. A two-entry command queue separates intake from execution;
// the back end takes a new command only while idle. A symbol item searches the
// table entries in order, up to min(entries_in_use, TABLE_DEPTH), one at a time
// through the single read port of the table RAM, stopping at the first match; a
// dead string skips the search. A last symbol then passes through the emit state,
// which loads the result register that drives out_ch. Reset clears state,
// registers and the queue; the table is undefined until written. When out_ch
// stalls, the result holds; loads and non-last symbols keep flowing until a
// second result is due.
module dfa_string_acceptor import dfa_pkg::*; #(
  parameter int TABLE_DEPTH = 64,
  parameter int NUM_STATES  = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  dfa_in_if.sink            in_ch,
  dfa_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  cmd_t       cmd;
  logic       cmd_valid;
  logic       cmd_ready;
  cfg_wr_t    cfg;
  back_stat_t stat;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_wdata;

  dfa_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  dfa_back #(.TABLE_DEPTH(TABLE_DEPTH), .NUM_STATES(NUM_STATES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cfg       (cfg),
    .out_ch    (out_ch),
    .stat      (stat)
  );

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && cmd_ready && !cmd.sym) |=> !$rose(out_ch.valid))
    else $error("load item produced a result");

  a_result_resets_string: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> (!stat.in_string && !stat.dead))
    else $error("string state not cleared with result");

  a_dead_within_string: assert property (@(posedge clk) disable iff (!rst_n)
    stat.dead |-> stat.in_string)
    else $error("dead flag set outside a string");

  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(!cmd_ready))
    else $error("result raised while back end idle");

endmodule
